>>> hw/rtl/psihdr_pkg.sv
// Shared constants and the result type for the PSI section header parser.
// No dependencies; imported by psihdr_crc_step and the parser top level.
package psihdr_pkg;

    // MPEG-2 CRC-32: MSB first, no reflection, no final XOR
    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Bits of header byte one and byte five
    localparam int unsigned SYNTAX_BIT  = 7;
    localparam int unsigned PRIVATE_BIT = 6;
    localparam int unsigned CURNEXT_BIT = 0;

    // Shortest long section total (section_length + 3) not flagged as too short
    localparam logic [12:0] MIN_LONG_TOTAL = 13'd9;
    // Table id byte plus the two bytes that carry section_length
    localparam logic [12:0] LEN_FIELD_BYTES = 13'd3;
    localparam int unsigned HDR_BYTES = 8;

    typedef logic [7:0] byte_t;

    // One parsed section header
    typedef struct packed {
        logic [7:0]  table_id;
        logic        syntax_flag;
        logic        private_flag;
        logic [11:0] section_length;
        logic [15:0] table_id_extension;
        logic [4:0]  version_number;
        logic        current_next;
        logic [7:0]  section_number;
        logic [7:0]  last_section_number;
        logic [31:0] crc_word;
        logic        crc_mismatch;
    } result_t;

endpackage

>>> hw/rtl/psihdr_crc_step.sv
// Byte-wide MPEG-2 CRC-32 update: one data byte folded into the running CRC.
// Depends on psihdr_pkg for the polynomial.
module psihdr_crc_step (
    input  logic [31:0] crc_in,
    input  logic [7:0]  data,
    output logic [31:0] crc_out
);
    import psihdr_pkg::*;

    logic [31:0] acc;

    // Shift eight bits through the polynomial divider, MSB first
    always_comb
    begin
        acc = crc_in ^ {data, 24'h0};
        for (int i = 0; i < 8; i++)
        begin
            if (acc[31])
            begin
                acc = {acc[30:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                acc = {acc[30:0], 1'b0};
            end
        end
        crc_out = acc;
    end

endmodule

>>> hw/rtl/psi_section_header_crc_parser_core.sv
// PSI section header parser with CRC-32 check, top level.
// Depends on psihdr_pkg and psihdr_crc_step.
//
// Takes one section byte per word on the byte channel and gives one result word
// on the result channel when the last byte of a section (section_length + 3
// bytes) has passed. The block takes one byte every cycle while results are
// taken: a byte is captured in an input register, and when it advances a
// single pass of header capture, byte-wide CRC update and length compare
// updates the section state and loads the result register. The result register
// and the input register together hold one pending result and one further byte;
// the byte stream stalls only while a finished result is not taken. A word with
// first_byte set starts a new section and drops one in progress; bytes outside
// a section are ignored.
module psi_section_header_crc_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    // byte channel
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    // result channel
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  table_id,
    output logic        syntax_flag,
    output logic        private_flag,
    output logic [11:0] section_length,
    output logic [15:0] table_id_extension,
    output logic [4:0]  version_number,
    output logic        current_next,
    output logic [7:0]  section_number,
    output logic [7:0]  last_section_number,
    output logic [31:0] crc_word,
    output logic        crc_mismatch
);
    import psihdr_pkg::*;

    // Input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;

    // Section state
    logic        in_sec_reg, in_sec_next;
    logic [12:0] cnt_reg, cnt_next;
    byte_t       hb_reg [HDR_BYTES];
    byte_t       hb_next [HDR_BYTES];
    logic [31:0] crc_reg, crc_next;
    logic [31:0] tail_reg, tail_next;

    // Result register
    logic        out_valid_reg;
    result_t     res_reg, res_next;

    logic        advance;
    logic        emit;
    logic        ins_e;
    logic [12:0] cnt_e;
    logic [31:0] crc_e;
    logic [31:0] crc_upd;
    logic [12:0] total;
    byte_t       b1;
    byte_t       b5;

    // Move the captured byte on when the result slot is free or being taken
    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign byte_ready = !in_valid_reg || advance;

    psihdr_crc_step u_crc (
        .crc_in  (crc_e),
        .data    (in_byte_reg),
        .crc_out (crc_upd)
    );

    // Section update for the byte in the input register
    always_comb
    begin
        ins_e = in_first_reg || in_sec_reg;
        cnt_e = in_first_reg ? '0 : cnt_reg;
        crc_e = in_first_reg ? CRC_INIT : crc_reg;
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            hb_next[i] = in_first_reg ? '0 : hb_reg[i];
        end
        tail_next   = in_first_reg ? '0 : tail_reg;
        crc_next    = crc_e;
        cnt_next    = cnt_e;
        in_sec_next = ins_e;
        emit        = 1'b0;

        if (ins_e)
        begin
            if (cnt_e < 13'(HDR_BYTES))
            begin
                hb_next[cnt_e[2:0]] = in_byte_reg;
            end
            crc_next  = crc_upd;
            tail_next = {tail_next[23:0], in_byte_reg};
            cnt_next  = cnt_e + 13'd1;
        end

        b1    = hb_next[1];
        b5    = hb_next[5];
        total = {1'b0, b1[3:0], hb_next[2]} + LEN_FIELD_BYTES;

        if (ins_e && cnt_next >= LEN_FIELD_BYTES && cnt_next == total)
        begin
            emit        = 1'b1;
            in_sec_next = 1'b0;
            cnt_next    = '0;
        end

        // Build the result; long-section fields stay zero for short sections
        res_next                = '0;
        res_next.table_id       = hb_next[0];
        res_next.syntax_flag    = b1[SYNTAX_BIT];
        res_next.private_flag   = b1[PRIVATE_BIT];
        res_next.section_length = {b1[3:0], hb_next[2]};
        if (b1[SYNTAX_BIT])
        begin
            res_next.table_id_extension  = {hb_next[3], hb_next[4]};
            res_next.version_number      = b5[5:1];
            res_next.current_next        = b5[CURNEXT_BIT];
            res_next.section_number      = hb_next[6];
            res_next.last_section_number = hb_next[7];
            res_next.crc_word            = tail_next;
            res_next.crc_mismatch        = (crc_next != '0) || (total < MIN_LONG_TOTAL);
        end
    end

    // Hold control state; capture bytes and advance the section
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_sec_reg    <= 1'b0;
            cnt_reg       <= '0;
            crc_reg       <= CRC_INIT;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HDR_BYTES; i++)
            begin
                hb_reg[i] <= '0;
            end
        end
        else
        begin
            if (byte_ready)
            begin
                in_valid_reg <= byte_valid;
            end
            if (advance)
            begin
                in_sec_reg <= in_sec_next;
                cnt_reg    <= cnt_next;
                crc_reg    <= crc_next;
                tail_reg   <= tail_next;
                for (int i = 0; i < HDR_BYTES; i++)
                begin
                    hb_reg[i] <= hb_next[i];
                end
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            in_byte_reg  <= data_byte;
            in_first_reg <= first_byte;
        end
        if (advance && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid        = out_valid_reg;
    assign table_id            = res_reg.table_id;
    assign syntax_flag         = res_reg.syntax_flag;
    assign private_flag        = res_reg.private_flag;
    assign section_length      = res_reg.section_length;
    assign table_id_extension  = res_reg.table_id_extension;
    assign version_number      = res_reg.version_number;
    assign current_next        = res_reg.current_next;
    assign section_number      = res_reg.section_number;
    assign last_section_number = res_reg.last_section_number;
    assign crc_word            = res_reg.crc_word;
    assign crc_mismatch        = res_reg.crc_mismatch;

    // Once the length field is in, the byte count stays below the section total
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_sec_reg && cnt_reg >= LEN_FIELD_BYTES) |->
        (cnt_reg < ({1'b0, hb_reg[1][3:0], hb_reg[2]} + LEN_FIELD_BYTES)))
    else $error("section byte count passed the section total");

    // A short section never reports a CRC word or a CRC error
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.syntax_flag) |->
        (!res_reg.crc_mismatch && res_reg.crc_word == '0))
    else $error("short section result carries CRC fields");

    // A captured byte is held while the result slot is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !result_ready) |=> in_valid_reg)
    else $error("captured byte lost while result stalled");

endmodule

>>> tb/psi_section_header_crc_parser_core_tb.sv
// Testbench for the PSI section header parser with CRC-32 check.
// Depends on psihdr_pkg and psi_section_header_crc_parser_core; drives byte words,
// predicts each result with its own section model and checks it field by field.
`timescale 1ns / 100ps

module psi_section_header_crc_parser_core_tb;

    import psihdr_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        first_byte = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [7:0]  table_id;
    logic        syntax_flag;
    logic        private_flag;
    logic [11:0] section_length;
    logic [15:0] table_id_extension;
    logic [4:0]  version_number;
    logic        current_next;
    logic [7:0]  section_number;
    logic [7:0]  last_section_number;
    logic [31:0] crc_word;
    logic        crc_mismatch;

    // Section model state
    logic [12:0] sec_count = '0;
    bit          sec_open = 1'b0;
    logic [63:0] sec_header = '0;
    logic [31:0] sec_crc = CRC_INIT;
    logic [31:0] sec_tail = '0;

    result_t     expected_headers [$];
    int          error_count = 0;
    int          result_index = 0;
    int          section_bytes = 0;
    int          rx_hold_cycles = 0;
    bit          no_idle = 1'b0;

    psi_section_header_crc_parser_core u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .byte_valid          (byte_valid),
        .byte_ready          (byte_ready),
        .data_byte           (data_byte),
        .first_byte          (first_byte),
        .result_valid        (result_valid),
        .result_ready        (result_ready),
        .table_id            (table_id),
        .syntax_flag         (syntax_flag),
        .private_flag        (private_flag),
        .section_length      (section_length),
        .table_id_extension  (table_id_extension),
        .version_number      (version_number),
        .current_next        (current_next),
        .section_number      (section_number),
        .last_section_number (last_section_number),
        .crc_word            (crc_word),
        .crc_mismatch        (crc_mismatch)
    );

    always #5 clk = ~clk;

    // Stop a hung run; slowest correct run is well under a tenth of this
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h0};
        for (int i = 0; i < 8; i++)
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    // Advance the section model by one accepted byte; queue a header at the last byte
    function automatic void predict_section_byte(input logic [7:0] b, input logic fb);
        logic [7:0]  b1;
        logic [7:0]  b5;
        logic [12:0] total;
        result_t     r;
        if (fb)
        begin
            sec_count  = '0;
            sec_open   = 1'b1;
            sec_header = '0;
            sec_crc    = CRC_INIT;
            sec_tail   = '0;
        end
        if (!sec_open)
            return;
        if (sec_count < HDR_BYTES)
            sec_header[63 - 8 * sec_count -: 8] = b;
        sec_crc   = crc32_update(sec_crc, b);
        sec_tail  = {sec_tail[23:0], b};
        sec_count = sec_count + 13'd1;
        if (sec_count < LEN_FIELD_BYTES)
            return;
        b1    = sec_header[55:48];
        total = {1'b0, b1[3:0], sec_header[47:40]} + LEN_FIELD_BYTES;
        if (sec_count != total)
            return;
        r                = '0;
        r.table_id       = sec_header[63:56];
        r.syntax_flag    = b1[SYNTAX_BIT];
        r.private_flag   = b1[PRIVATE_BIT];
        r.section_length = {b1[3:0], sec_header[47:40]};
        if (b1[SYNTAX_BIT])
        begin
            b5                    = sec_header[23:16];
            r.table_id_extension  = sec_header[39:24];
            r.version_number      = b5[5:1];
            r.current_next        = b5[CURNEXT_BIT];
            r.section_number      = sec_header[15:8];
            r.last_section_number = sec_header[7:0];
            r.crc_word            = sec_tail;
            r.crc_mismatch        = (sec_crc != 32'h0) || (total < MIN_LONG_TOTAL);
        end
        expected_headers.push_back(r);
        sec_open  = 1'b0;
        sec_count = '0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string field, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                      result_index, field, got, want));
    endtask

    // Compare each accepted result word with the oldest queued header
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_headers.size() == 0)
                report_mismatch($sformatf("result %0d arrived with none pending", result_index));
            else
            begin
                want = expected_headers.pop_front();
                check_field("table_id", 32'(table_id), 32'(want.table_id));
                check_field("syntax_flag", 32'(syntax_flag), 32'(want.syntax_flag));
                check_field("private_flag", 32'(private_flag), 32'(want.private_flag));
                check_field("section_length", 32'(section_length),
                            32'(want.section_length));
                check_field("table_id_extension", 32'(table_id_extension),
                            32'(want.table_id_extension));
                check_field("version_number", 32'(version_number),
                            32'(want.version_number));
                check_field("current_next", 32'(current_next), 32'(want.current_next));
                check_field("section_number", 32'(section_number),
                            32'(want.section_number));
                check_field("last_section_number", 32'(last_section_number),
                            32'(want.last_section_number));
                check_field("crc_word", crc_word, want.crc_word);
                check_field("crc_mismatch", 32'(crc_mismatch), 32'(want.crc_mismatch));
            end
            result_index++;
        end
    end

    // Result sink: random stall per word, or a long hold when requested
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                result_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            else
            begin
                stall = draw_wait();
                if (stall > 0)
                begin
                    result_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid && rx_hold_cycles == 0);
        end
    end

    // Offer one byte word after a random gap; valid stays high across back-to-back words
    task automatic send_byte(input logic [7:0] b, input logic fb);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= b;
        first_byte <= fb;
        do
            @(posedge clk);
        while (!byte_ready);
        predict_section_byte(b, fb);
    endtask

    // Build a section with random content; seal puts a valid CRC at the end,
    // flip corrupts one bit past the length field, cut stops early
    task automatic send_section(input bit long_form, input int unsigned len, input bit seal,
                                input bit flip, input int unsigned cut);
        logic [7:0]  sec [];
        logic [31:0] crc;
        logic [11:0] len12;
        logic [7:0]  tmp;
        int unsigned total;
        int unsigned n;
        int unsigned pos;
        total = len + 3;
        len12 = len[11:0];
        sec   = new[total];
        foreach (sec[i])
            sec[i] = 8'($urandom_range(0, 255));
        tmp    = sec[1];
        sec[1] = {long_form, tmp[6:4], len12[11:8]};
        sec[2] = len12[7:0];
        if (long_form && seal && total >= 7)
        begin
            crc = CRC_INIT;
            for (int i = 0; i < total - 4; i++)
                crc = crc32_update(crc, sec[i]);
            {sec[total-4], sec[total-3], sec[total-2], sec[total-1]} = crc;
        end
        if (flip && total > 3)
        begin
            pos      = $urandom_range(3, total - 1);
            tmp      = sec[pos];
            sec[pos] = tmp ^ (8'h01 << $urandom_range(0, 7));
        end
        n = (cut != 0 && cut < total) ? cut : total;
        for (int i = 0; i < n; i++)
            send_byte(sec[i], i == 0);
        section_bytes += n;
    endtask

    // Drop valid and hold until every queued header has come back
    task automatic pause_until_drained();
        byte_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_headers.size() != 0);
    endtask

    task automatic test_idle_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_short_and_abandoned();
        // empty short section, all-ones id and private/reserved bits
        send_byte(8'hFF, 1'b1);
        send_byte(8'h70, 1'b0);
        send_byte(8'h00, 1'b0);
        // drop a long section after four bytes
        send_section(1'b1, 10, 1'b1, 1'b0, 4);
    endtask

    task automatic test_long_too_short();
        // long section with no body: crc_word holds only three bytes
        send_byte(8'h00, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        // eight bytes: full header but too short for a CRC
        send_byte(8'h02, 1'b1);
        send_byte(8'hB0, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hC1, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_minimal_long();
        send_section(1'b1, 6, 1'b1, 1'b0, 0);
    endtask

    // Largest length field; the section is dropped by the next section start
    task automatic test_max_length();
        send_section(1'b1, 4095, 1'b1, 1'b0, 40);
    endtask

    task automatic test_back_pressure();
        rx_hold_cycles = 300;
        no_idle = 1'b1;
        for (int i = 0; i < 6; i++)
            send_section(1'b1, $urandom_range(6, 12), 1'b1, 1'b0, 0);
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause();
        send_section(1'b0, $urandom_range(0, 8), 1'b0, 1'b0, 0);
        send_section(1'b1, $urandom_range(6, 12), 1'b1, 1'b0, 0);
        pause_until_drained();
        send_section(1'b1, $urandom_range(6, 12), 1'b1, 1'b1, 0);
    endtask

    task automatic test_random_stream();
        int unsigned pick;
        int          start;
        int unsigned len;
        start = section_bytes;
        while (section_bytes - start < 400)
        begin
            pick    = $urandom_range(0, 99);
            no_idle = ($urandom_range(0, 9) == 0);
            if (pick < 50)
                send_section(1'b1, $urandom_range(6, 24), 1'b1, $urandom_range(0, 4) == 0, 0);
            else if (pick < 70)
                send_section(1'b0, $urandom_range(0, 16), 1'b0, 1'b0, 0);
            else if (pick < 78)
                send_section(1'b1, $urandom_range(0, 5), 1'b1, 1'b0, 0);
            else if (pick < 86)
            begin
                len = $urandom_range(6, 20);
                send_section(1'($urandom_range(0, 1)), len, 1'b1, 1'b0,
                             $urandom_range(1, len + 2));
            end
            else if (pick < 94)
            begin
                // stray words with no section start
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            else if (pick < 95)
                send_section(1'b1, $urandom_range(60, 120), 1'b1, 1'b0, 0);
            else
                send_section(1'b1, $urandom_range(6, 24), 1'b0, 1'b0, 0);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        int guard;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_bytes();
        test_short_and_abandoned();
        test_long_too_short();
        test_minimal_long();
        test_back_pressure();
        test_drain_pause();
        test_max_length();
        test_random_stream();

        // Drain the remaining results, then let the pipeline settle
        byte_valid <= 1'b0;
        guard = 0;
        while (expected_headers.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (expected_headers.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_headers.size()));

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
